// ===== hw/rtl/motion_window_direction_classifier_core_defines.svh =====
// Assertion macros for the RTL of the classifier core; mwdc_back.sv includes them.
`ifndef MOTION_WINDOW_DIRECTION_CLASSIFIER_CORE_DEFINES_SVH
`define MOTION_WINDOW_DIRECTION_CLASSIFIER_CORE_DEFINES_SVH

`define MWDC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

`define MWDC_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define MWDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mwdc_pkg.sv =====
`timescale 1ns / 1ps
package mwdc_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int COUNT_BITS     = 16;
    localparam int THR_BITS       = 23;
    localparam int LEN_BITS       = 6;
    localparam int CFG_DATA_BITS  = 23;
    localparam int CFG_IDX_BITS   = 2;
    localparam int WINDOW_MAX_DEF = 32;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LEN = 2'd1;

    localparam logic [THR_BITS-1:0] THR_RESET = 23'd16;
    localparam logic [LEN_BITS-1:0] LEN_RESET = 6'd8;

    typedef enum logic [3:0] {
        DIR_NONE       = 4'd0,
        DIR_DOWN_LEFT  = 4'd1,
        DIR_UP_LEFT    = 4'd2,
        DIR_DOWN_RIGHT = 4'd3,
        DIR_UP_RIGHT   = 4'd4,
        DIR_RIGHT      = 4'd5,
        DIR_LEFT       = 4'd6,
        DIR_UP         = 4'd7,
        DIR_DOWN       = 4'd8
    } t_dir;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] motion_x_total;
        logic signed [SAMPLE_BITS-1:0] motion_y_total;
        logic [COUNT_BITS-1:0]         point_count;
    } t_item;

    typedef struct packed {
        t_dir                          direction;
        logic signed [SAMPLE_BITS-1:0] mean_x;
        logic signed [SAMPLE_BITS-1:0] mean_y;
        logic                          zero_count_flag;
    } t_result;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] avg_x;
        logic signed [SAMPLE_BITS-1:0] avg_y;
        logic                          zero_count_flag;
    } t_avg;

    typedef struct packed {
        logic [THR_BITS-1:0] thr;
        logic [LEN_BITS-1:0] wlen;
        logic                clear;
    } t_win_cfg;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_UPD,
        B_DIV,
        B_OUT
    } t_back_state;

endpackage

// ===== hw/rtl/motion_window_direction_classifier_core.sv =====
`timescale 1ns / 1ps
// The bit-serial divide of the window sums in the back stage bounds the item rate; the
// front divide of the motion sums works on the next item while the back handles the last.
// Reset is synchronous and active low; it empties the window and both queues and
// restores the threshold to 16 and the window length to 8.
module motion_window_direction_classifier_core #(
    parameter int WINDOW_MAX = mwdc_pkg::WINDOW_MAX_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  mwdc_pkg::t_item                      i_item,
    output logic                                 empty,
    input  logic                                 pop,
    output mwdc_pkg::t_result                    o_result,
    input  logic                                 i_cfg_we,
    input  logic [mwdc_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [mwdc_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    import mwdc_pkg::*;

    logic [THR_BITS-1:0] r_thr;
    logic [LEN_BITS-1:0] r_wlen;
    t_win_cfg            win_cfg;
    logic                mid_push, mid_full, mid_pop, mid_empty;
    t_avg                mid_in, mid_out;
    logic                res_push, res_full;
    t_result             res_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= THR_RESET;
            r_wlen <= LEN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_THRESHOLD: begin
                    r_thr <= i_cfg_data[THR_BITS-1:0];
                end
                CFG_WINDOW_LEN: begin
                    r_wlen <= i_cfg_data[LEN_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Any write of the window length empties the window.
    always_comb begin
        win_cfg.thr   = r_thr;
        win_cfg.wlen  = r_wlen;
        win_cfg.clear = i_cfg_we && (i_cfg_idx == CFG_WINDOW_LEN);
    end

    mwdc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (i_item),
        .o_full   (full),
        .o_q_push (mid_push),
        .o_q_data (mid_in),
        .i_q_full (mid_full)
    );

    mwdc_fifo #(
        .T     (t_avg),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_data  (mid_in),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_data  (mid_out),
        .o_empty (mid_empty)
    );

    mwdc_back #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (win_cfg),
        .i_q_empty (mid_empty),
        .o_q_pop   (mid_pop),
        .i_q_data  (mid_out),
        .o_r_push  (res_push),
        .o_r_data  (res_in),
        .i_r_full  (res_full)
    );

    mwdc_fifo #(
        .T     (t_result),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

endmodule

// ===== hw/rtl/mwdc_div.sv =====
`timescale 1ns / 1ps
module mwdc_div #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0]        i_den,
    output logic                    o_done,
    output logic signed [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic             r_neg, n_neg;
    logic [NUM_W-1:0] r_q, n_q;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_den, n_den;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   trial;

    // Restoring division of the magnitude, one quotient bit per cycle.
    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_neg   = r_neg;
        n_q     = r_q;
        n_rem   = r_rem;
        n_den   = r_den;
        n_cnt   = r_cnt;
        shifted = {r_rem, r_q[NUM_W-1]};
        trial   = shifted - {1'b0, r_den};
        if (i_start) begin
            n_busy = 1'b1;
            n_neg  = i_num[NUM_W-1];
            n_q    = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
            n_rem  = '0;
            n_den  = i_den;
            n_cnt  = CNT_W'(NUM_W);
        end else if (r_busy) begin
            if (shifted >= {1'b0, r_den}) begin
                n_rem = trial[DEN_W-1:0];
                n_q   = {r_q[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = shifted[DEN_W-1:0];
                n_q   = {r_q[NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg <= n_neg;
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_q) : $signed(r_q);

endmodule

// ===== hw/rtl/mwdc_fifo.sv =====
`timescale 1ns / 1ps
module mwdc_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output T     o_data,
    output logic o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T              r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        do_push = i_push && !o_full;
        do_pop  = i_pop && !o_empty;
        n_wr    = r_wr;
        n_rd    = r_rd;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        n_cnt = r_cnt + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== hw/rtl/mwdc_front.sv =====
`timescale 1ns / 1ps
module mwdc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mwdc_pkg::t_item i_item,
    output logic            o_full,
    output logic            o_q_push,
    output mwdc_pkg::t_avg  o_q_data,
    input  logic            i_q_full
);

    import mwdc_pkg::*;

    t_front_state                  r_state, n_state;
    logic                          accept;
    logic                          done_x, done_y;
    logic signed [SAMPLE_BITS-1:0] quot_x, quot_y;
    logic                          r_flag;
    t_avg                          r_avg;

    assign accept = i_push && (r_state == F_IDLE);

    mwdc_div #(
        .NUM_W (SAMPLE_BITS),
        .DEN_W (COUNT_BITS)
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_num   (i_item.motion_x_total),
        .i_den   (i_item.point_count),
        .o_done  (done_x),
        .o_quot  (quot_x)
    );

    mwdc_div #(
        .NUM_W (SAMPLE_BITS),
        .DEN_W (COUNT_BITS)
    ) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_num   (i_item.motion_y_total),
        .i_den   (i_item.point_count),
        .o_done  (done_y),
        .o_quot  (quot_y)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (accept) begin
                    n_state = F_DIV;
                end
            end
            F_DIV: begin
                if (done_x && done_y) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_q_full) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_comb begin
        o_full   = (r_state != F_IDLE);
        o_q_push = (r_state == F_PUSH) && !i_q_full;
        o_q_data = r_avg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A zero point count stores zero motion in place of the quotient.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_flag <= (i_item.point_count == '0);
        end
        if ((r_state == F_DIV) && done_x && done_y) begin
            r_avg.avg_x           <= r_flag ? '0 : quot_x;
            r_avg.avg_y           <= r_flag ? '0 : quot_y;
            r_avg.zero_count_flag <= r_flag;
        end
    end

endmodule

// ===== hw/rtl/mwdc_back.sv =====
`timescale 1ns / 1ps
`include "motion_window_direction_classifier_core_defines.svh"
module mwdc_back #(
    parameter int WINDOW_MAX = mwdc_pkg::WINDOW_MAX_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mwdc_pkg::t_win_cfg i_cfg,
    input  logic               i_q_empty,
    output logic               o_q_pop,
    input  mwdc_pkg::t_avg     i_q_data,
    output logic               o_r_push,
    output mwdc_pkg::t_result  o_r_data,
    input  logic               i_r_full
);

    import mwdc_pkg::*;

    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int LCW   = ($clog2(WINDOW_MAX + 1) > LEN_BITS) ? $clog2(WINDOW_MAX + 1)
                                                               : LEN_BITS;
    localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_MAX);

    t_back_state                   r_state, n_state;
    logic signed [SAMPLE_BITS-1:0] r_hist_x [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0] r_hist_y [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0] r_old_x, r_old_y;
    logic signed [SAMPLE_BITS-1:0] r_ax, r_ay;
    logic signed [SAMPLE_BITS-1:0] r_mx, r_my;
    logic                          r_flag;
    logic [IDX_W-1:0]              r_slot, n_slot;
    logic [LCW-1:0]                r_fill, n_fill;
    logic signed [SUM_W-1:0]       r_sum_x, n_sum_x;
    logic signed [SUM_W-1:0]       r_sum_y, n_sum_y;
    logic [LCW-1:0]                len_raw, win_len;
    logic [LCW:0]                  old_wide;
    logic [IDX_W-1:0]              old_idx;
    logic                          drop;
    logic                          div_start;
    logic                          div_done_x, div_done_y;
    logic signed [SUM_W-1:0]       quot_x, quot_y;

    function automatic t_dir classify(input logic signed [SAMPLE_BITS-1:0] mx,
                                      input logic signed [SAMPLE_BITS-1:0] my,
                                      input logic [THR_BITS-1:0]           thr);
        logic signed [SAMPLE_BITS:0] t_pos, t_neg, ex, ey;
        logic                        xp, xn, yp, yn;
        t_dir                        d;
        t_pos = $signed((SAMPLE_BITS + 1)'(thr));
        t_neg = -t_pos;
        ex    = (SAMPLE_BITS + 1)'(mx);
        ey    = (SAMPLE_BITS + 1)'(my);
        xp    = ex > t_pos;
        xn    = ex < t_neg;
        yp    = ey > t_pos;
        yn    = ey < t_neg;
        if (xp && yp) begin
            d = DIR_DOWN_LEFT;
        end else if (xp && yn) begin
            d = DIR_UP_LEFT;
        end else if (xn && yp) begin
            d = DIR_DOWN_RIGHT;
        end else if (xn && yn) begin
            d = DIR_UP_RIGHT;
        end else if (xn) begin
            d = DIR_RIGHT;
        end else if (xp) begin
            d = DIR_LEFT;
        end else if (yn) begin
            d = DIR_UP;
        end else if (yp) begin
            d = DIR_DOWN;
        end else begin
            d = DIR_NONE;
        end
        return d;
    endfunction

    // Window length clamped to the range the ring can hold.
    always_comb begin
        len_raw = LCW'(i_cfg.wlen);
        if (len_raw == '0) begin
            win_len = LCW'(1);
        end else if (len_raw > LCW'(WINDOW_MAX)) begin
            win_len = LCW'(WINDOW_MAX);
        end else begin
            win_len = len_raw;
        end
        old_wide = (LCW + 1)'(r_slot) + (LCW + 1)'(WINDOW_MAX) - (LCW + 1)'(win_len);
        if (old_wide >= (LCW + 1)'(WINDOW_MAX)) begin
            old_wide = old_wide - (LCW + 1)'(WINDOW_MAX);
        end
        old_idx = old_wide[IDX_W-1:0];
    end

    // The oldest entry leaves the sums once the window is full.
    always_comb begin
        drop    = (r_fill >= win_len);
        n_sum_x = r_sum_x - (drop ? SUM_W'(r_old_x) : '0) + SUM_W'(r_ax);
        n_sum_y = r_sum_y - (drop ? SUM_W'(r_old_y) : '0) + SUM_W'(r_ay);
        n_fill  = drop ? win_len : r_fill + LCW'(1);
        n_slot  = (r_slot == IDX_W'(WINDOW_MAX - 1)) ? '0 : r_slot + IDX_W'(1);
    end

    mwdc_div #(
        .NUM_W (SUM_W),
        .DEN_W (LCW)
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (n_sum_x),
        .i_den   (n_fill),
        .o_done  (div_done_x),
        .o_quot  (quot_x)
    );

    mwdc_div #(
        .NUM_W (SUM_W),
        .DEN_W (LCW)
    ) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (n_sum_y),
        .i_den   (n_fill),
        .o_done  (div_done_y),
        .o_quot  (quot_y)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    n_state = B_UPD;
                end
            end
            B_UPD: begin
                n_state = B_DIV;
            end
            B_DIV: begin
                if (div_done_x && div_done_y) begin
                    n_state = B_OUT;
                end
            end
            B_OUT: begin
                if (!i_r_full) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_comb begin
        o_q_pop                  = (r_state == B_IDLE) && !i_q_empty;
        div_start                = (r_state == B_UPD);
        o_r_push                 = (r_state == B_OUT) && !i_r_full;
        o_r_data.direction       = classify(r_mx, r_my, i_cfg.thr);
        o_r_data.mean_x          = r_mx;
        o_r_data.mean_y          = r_my;
        o_r_data.zero_count_flag = r_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_slot  <= '0;
            r_fill  <= '0;
            r_sum_x <= '0;
            r_sum_y <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg.clear) begin
                r_slot  <= '0;
                r_fill  <= '0;
                r_sum_x <= '0;
                r_sum_y <= '0;
            end else if (r_state == B_UPD) begin
                r_slot  <= n_slot;
                r_fill  <= n_fill;
                r_sum_x <= n_sum_x;
                r_sum_y <= n_sum_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_ax    <= i_q_data.avg_x;
            r_ay    <= i_q_data.avg_y;
            r_flag  <= i_q_data.zero_count_flag;
            r_old_x <= r_hist_x[old_idx];
            r_old_y <= r_hist_y[old_idx];
        end
        if (r_state == B_UPD) begin
            r_hist_x[r_slot] <= r_ax;
            r_hist_y[r_slot] <= r_ay;
        end
        if ((r_state == B_DIV) && div_done_x && div_done_y) begin
            r_mx <= quot_x[SAMPLE_BITS-1:0];
            r_my <= quot_y[SAMPLE_BITS-1:0];
        end
    end

    `MWDC_ASSERT_ALWAYS(a_fill_in_window, r_fill <= win_len, "window fill beyond its length")
    `MWDC_ASSERT_ALWAYS(a_slot_in_ring, LCW'(r_slot) < LCW'(WINDOW_MAX), "ring slot out of range")
    `MWDC_ASSERT_NEXT(a_pop_updates, o_q_pop, r_state == B_UPD, "item popped without update")
    `MWDC_ASSERT_IMPLY(a_done_in_div, div_done_x || div_done_y, r_state == B_DIV, "stray divide")

endmodule
